>>> rtl/core/usb_port_overheat_guard_assert.svh
// assertion macros for the usb port overheat guard checker
`ifndef USB_PORT_OVERHEAT_GUARD_ASSERT_SVH
`define USB_PORT_OVERHEAT_GUARD_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UPOG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upog assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define UPOG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upog assertion failed");

`endif

>>> rtl/core/upog_pkg.sv
// shared types and constants for the usb port overheat guard
package upog_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_TEMP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TEMP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_EVERY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCESSORY_WATCH_S = 3'd4;

  localparam logic [15:0] ACC_WATCH_RST = 16'd5;

  localparam logic [1:0] EV_NONE       = 2'd0;
  localparam logic [1:0] EV_TRIGGERED  = 2'd1;
  localparam logic [1:0] EV_CLEARED    = 2'd2;
  localparam logic [1:0] EV_READ_ERROR = 2'd3;

  typedef struct packed {
    logic               guard_enable;
    logic signed [15:0] trip_temp;
    logic signed [15:0] release_temp;
    logic [7:0]         sample_every;
    logic [15:0]        accessory_watch_s;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] port_temp;
    logic               status_ok;
    logic               host_online;
    logic               accessory_sink;
    logic [31:0]        now_seconds;
  } item_t;

  typedef struct packed {
    logic       mitigating;
    logic       keep_polling;
    logic [1:0] event_code;
  } res_t;

endpackage

>>> rtl/core/upog_cfg_regs.sv
// configuration register bank of the overheat guard
module upog_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [upog_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [upog_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output upog_pkg::cfg_t                  cfg
);
  import upog_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.guard_enable      <= 1'b1;
      cfg_r.trip_temp         <= '0;
      cfg_r.release_temp      <= '0;
      cfg_r.sample_every      <= 8'd1;
      cfg_r.accessory_watch_s <= ACC_WATCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GUARD_ENABLE:      cfg_r.guard_enable      <= cfg_wdata[0];
        CFG_TRIP_TEMP:         cfg_r.trip_temp         <= cfg_wdata;
        CFG_RELEASE_TEMP:      cfg_r.release_temp      <= cfg_wdata;
        CFG_SAMPLE_EVERY:      cfg_r.sample_every      <= cfg_wdata[7:0];
        CFG_ACCESSORY_WATCH_S: cfg_r.accessory_watch_s <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/upog_in_reg.sv
// input register stage holding one poll request
module upog_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  upog_pkg::item_t in_item,
  input  logic            advance,
  output logic            s1_valid,
  output upog_pkg::item_t s1_item
);
  import upog_pkg::*;

  logic  s1_valid_r;
  logic  s1_valid_nxt;
  item_t s1_item_r;
  logic  accept;

  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

>>> rtl/core/upog_step.sv
// guard state and per-poll decision logic
module upog_step (
  input  logic            clk,
  input  logic            rst_n,
  input  upog_pkg::cfg_t  cfg,
  input  logic            s1_valid,
  input  upog_pkg::item_t s1_item,
  input  logic            out_ready,
  output logic            advance,
  output upog_pkg::res_t  res
);
  import upog_pkg::*;

  logic        mit_r, mit_nxt;
  logic        host_r, host_nxt;
  logic        acc_r, acc_nxt;
  logic        replug_r, replug_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [31:0] since_r, since_nxt;

  logic        temp_neg;
  logic        below_rel;
  logic        above_trip;
  logic [7:0]  mod_val;
  logic [8:0]  cnt_inc;
  logic [7:0]  cnt_wrap;
  logic        sampling;
  logic        due;
  logic        err;
  logic        clear;
  logic        trig;
  logic [31:0] elapsed;
  logic        in_window;
  logic        reduce;

  assign temp_neg   = s1_item.port_temp[15];
  assign below_rel  = s1_item.port_temp < cfg.release_temp;
  assign above_trip = s1_item.port_temp > cfg.trip_temp;
  assign mod_val    = (cfg.sample_every == 8'd0) ? 8'd1 : cfg.sample_every;
  assign cnt_inc    = {1'b0, cnt_r} + 9'd1;
  assign cnt_wrap   = (cnt_inc == {1'b0, mod_val}) ? 8'd0 : cnt_inc[7:0];
  assign sampling   = cfg.guard_enable && !temp_neg && (!mit_r || below_rel);

  // counter left at or above a new period is brought into range first
  assign reduce  = s1_valid && sampling && mit_r && (cnt_r >= mod_val);
  assign advance = s1_valid && out_ready && !reduce;

  always_comb begin
    mit_nxt    = mit_r;
    host_nxt   = host_r;
    acc_nxt    = acc_r;
    replug_nxt = replug_r;
    cnt_nxt    = cnt_r;
    since_nxt  = since_r;
    due        = 1'b1;
    err        = cfg.guard_enable && temp_neg;

    if (sampling) begin
      if (mit_r) begin
        cnt_nxt = cnt_wrap;
        due     = (cnt_wrap == 8'd0);
      end
      if (due) begin
        if (!s1_item.status_ok) begin
          err = 1'b1;
        end else begin
          host_nxt = s1_item.host_online;
          acc_nxt  = s1_item.accessory_sink;
          if (!acc_r && s1_item.accessory_sink) begin
            since_nxt = s1_item.now_seconds;
          end
          if (mit_r && !s1_item.host_online && !s1_item.accessory_sink &&
              !host_r && !acc_r) begin
            replug_nxt = 1'b1;
          end
        end
      end
    end

    clear = mit_r && (!cfg.guard_enable || (below_rel && replug_nxt));
    trig  = !mit_r && cfg.guard_enable && above_trip;
    res.event_code = EV_NONE;

    priority if (err) begin
      res.event_code = EV_READ_ERROR;
    end else if (clear) begin
      mit_nxt        = 1'b0;
      replug_nxt     = 1'b0;
      res.event_code = EV_CLEARED;
    end else if (trig) begin
      mit_nxt        = 1'b1;
      replug_nxt     = 1'b0;
      res.event_code = EV_TRIGGERED;
    end

    elapsed   = s1_item.now_seconds - since_nxt;
    in_window = elapsed < {16'd0, cfg.accessory_watch_s};

    if (err) begin
      res.mitigating   = mit_r;
      res.keep_polling = 1'b1;
    end else begin
      res.mitigating   = mit_nxt;
      res.keep_polling = mit_nxt || host_nxt || (acc_nxt && in_window);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mit_r    <= 1'b0;
      host_r   <= 1'b0;
      acc_r    <= 1'b0;
      replug_r <= 1'b0;
      cnt_r    <= '0;
      since_r  <= '0;
    end else if (advance) begin
      // status read error keeps only the counter step
      mit_r   <= mit_nxt;
      cnt_r   <= cnt_nxt;
      if (!err) begin
        host_r   <= host_nxt;
        acc_r    <= acc_nxt;
        replug_r <= replug_nxt;
        since_r  <= since_nxt;
      end
    end else if (reduce) begin
      cnt_r <= cnt_r - mod_val;
    end
  end

endmodule

>>> rtl/core/upog_out_reg.sv
// result register stage toward the consumer
module upog_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  upog_pkg::res_t res,
  output logic           out_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_mitigating,
  output logic           out_keep_polling,
  output logic [1:0]     out_event_code
);
  import upog_pkg::*;

  logic out_valid_r;
  logic out_valid_nxt;
  res_t res_r;

  assign out_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mitigating   = res_r.mitigating;
  assign out_keep_polling = res_r.keep_polling;
  assign out_event_code   = res_r.event_code;

endmodule

>>> rtl/core/usb_port_overheat_guard.sv
// usb port overheat guard top level
//
//   channel  direction  handshake          payload
//   in_      request    in_valid/in_stall  port_temp status_ok host_online
//                                          accessory_sink now_seconds
//   out_     result     out_valid/out_stall mitigating keep_polling event_code
//   cfg_     write      cfg_we             cfg_index cfg_wdata
//
// one request per cycle unless out_stall or a counter reduction holds it
// path: input register, decision logic, result register, which drives out_valid
// while mitigating, a sample counter at or above a newly written sample_every is
// reduced by one subtraction per cycle before that request proceeds
// rst_n is synchronous; reset needs no clearing pass
// out_stall holds the result and reaches in_stall combinationally, no skid stage
module usb_port_overheat_guard (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              in_port_temp,
  input  logic                            in_status_ok,
  input  logic                            in_host_online,
  input  logic                            in_accessory_sink,
  input  logic [31:0]                     in_now_seconds,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_mitigating,
  output logic                            out_keep_polling,
  output logic [1:0]                      out_event_code,
  input  logic                            cfg_we,
  input  logic [upog_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [upog_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import upog_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t s1_item;
  res_t  res;
  logic  s1_valid;
  logic  advance;
  logic  out_ready;

  assign in_item.port_temp      = in_port_temp;
  assign in_item.status_ok      = in_status_ok;
  assign in_item.host_online    = in_host_online;
  assign in_item.accessory_sink = in_accessory_sink;
  assign in_item.now_seconds    = in_now_seconds;

  upog_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  upog_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  upog_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .out_ready (out_ready),
    .advance   (advance),
    .res       (res)
  );

  upog_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (advance),
    .res              (res),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mitigating   (out_mitigating),
    .out_keep_polling (out_keep_polling),
    .out_event_code   (out_event_code)
  );

endmodule

>>> rtl/core/upog_checker.sv
// port-level checker for the overheat guard and its bind
`include "usb_port_overheat_guard_assert.svh"

module upog_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_mitigating,
  input logic       out_keep_polling,
  input logic [1:0] out_event_code
);
  import upog_pkg::*;

  `UPOG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_mitigating) && $stable(out_keep_polling) && $stable(out_event_code))
  `UPOG_ASSERT_IMP(a_trig_mitigates, out_valid && (out_event_code == EV_TRIGGERED), out_mitigating && out_keep_polling)
  `UPOG_ASSERT_IMP(a_clear_releases, out_valid && (out_event_code == EV_CLEARED), !out_mitigating)
  `UPOG_ASSERT_IMP(a_mitigating_polls, out_valid && out_mitigating, out_keep_polling)

endmodule

bind usb_port_overheat_guard upog_checker u_upog_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_mitigating   (out_mitigating),
  .out_keep_polling (out_keep_polling),
  .out_event_code   (out_event_code)
);
